/* rtl/core/slope_climb_speed_sequencer_macros.svh */
// Assertion macros shared by the slope climb speed sequencer RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SLOPE_CLIMB_SPEED_SEQUENCER_MACROS_SVH
`define SLOPE_CLIMB_SPEED_SEQUENCER_MACROS_SVH

// Checked property, ignored while the synchronous reset is asserted.
`define SCSS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define SCSS_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/scss_pkg.sv */
// Package for the slope climb speed sequencer: types, codes and constants.
// Used by every RTL file of the block; has no dependencies.
package scss_pkg;

  localparam int PITCH_W = 13;
  localparam int SPEED_W = 16;
  localparam int MAXSPD_W = 15;
  localparam int STEP_W = 12;
  localparam int PHASE_W = 2;
  localparam int HOLD_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;
  // Angle compares run at this width so plane - 5 degrees cannot wrap.
  localparam int ANG_W = 15;

  localparam int HOLD_TICKS = 100;

  localparam logic signed [ANG_W-1:0] ONE_DEG = 15'sd16;
  localparam logic signed [ANG_W-1:0] FIVE_DEG = 15'sd80;
  localparam logic signed [SPEED_W:0] SPEED_SAT = 17'sd32767;

  // Codes of the phase field of a result.
  localparam logic [PHASE_W-1:0] OUT_PH_ACCEL = 2'd0;
  localparam logic [PHASE_W-1:0] OUT_PH_CLIMB = 2'd1;
  localparam logic [PHASE_W-1:0] OUT_PH_BRAKE = 2'd2;
  localparam logic [PHASE_W-1:0] OUT_PH_HOLD = 2'd3;

  typedef enum logic [2:0] {
    PH_PRIME,
    PH_ACCEL,
    PH_CLIMB,
    PH_BRAKE,
    PH_HOLD,
    PH_DONE
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLAT_PITCH,
    REG_MAX_SPEED,
    REG_ACCEL_STEP,
    REG_DECEL_STEP
  } cfg_idx_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] flat_pitch;
    logic [MAXSPD_W-1:0]       max_speed;
    logic [STEP_W-1:0]         accel_step;
    logic [STEP_W-1:0]         decel_step;
  } cfg_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_cmd;
    logic [PHASE_W-1:0]        phase;
  } result_t;

endpackage

/* rtl/core/scss_ifs.sv */
// Valid/ready stream interfaces for the pitch input and the speed command output.
// Depends on scss_pkg for field widths.
interface scss_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [scss_pkg::PITCH_W-1:0]  pitch;

  modport source (output valid, output pitch, input ready);
  modport sink (input valid, input pitch, output ready);
endinterface

interface scss_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [scss_pkg::SPEED_W-1:0]  speed_cmd;
  logic [scss_pkg::PHASE_W-1:0]         phase;

  modport source (output valid, output speed_cmd, output phase, input ready);
  modport sink (input valid, input speed_cmd, input phase, output ready);
endinterface

/* rtl/core/scss_cfg_regs.sv */
// Configuration register file of the slope climb speed sequencer.
// Depends on scss_pkg for the register index codes and the cfg_t bundle.
module scss_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [scss_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [scss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output scss_pkg::cfg_t                      cfg
);

  scss_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (scss_pkg::cfg_idx_t'(cfg_idx))
        scss_pkg::REG_FLAT_PITCH:  cfg_nxt.flat_pitch = cfg_wdata[scss_pkg::PITCH_W-1:0];
        scss_pkg::REG_MAX_SPEED:   cfg_nxt.max_speed = cfg_wdata[scss_pkg::MAXSPD_W-1:0];
        scss_pkg::REG_ACCEL_STEP:  cfg_nxt.accel_step = cfg_wdata[scss_pkg::STEP_W-1:0];
        scss_pkg::REG_DECEL_STEP:  cfg_nxt.decel_step = cfg_wdata[scss_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flat_pitch <= 13'sd0;
      cfg_r.max_speed <= 15'd8192;
      cfg_r.accel_step <= 12'd64;
      cfg_r.decel_step <= 12'd64;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/scss_in_stage.sv */
// Input register of the sequencer: holds one pitch sample until the step logic takes it.
// Depends on scss_pkg and the scss_in_if interface.
module scss_in_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  scss_in_if.sink                             in_ch,
  input  logic                                take,
  output logic                                item_valid,
  output logic signed [scss_pkg::PITCH_W-1:0] item_pitch
);

  logic                                valid_r, valid_nxt;
  logic signed [scss_pkg::PITCH_W-1:0] pitch_r;
  logic                                load;

  // The register frees up in the same cycle that its item moves on.
  assign in_ch.ready = !valid_r || take;
  assign load = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pitch_r <= in_ch.pitch;
    end
  end

  assign item_valid = valid_r;
  assign item_pitch = pitch_r;

endmodule

/* rtl/core/scss_step.sv */
// Phase sequencer and speed update: processes one pitch item per transfer into the step logic.
// Depends on scss_pkg and the assertion macros header.
`include "slope_climb_speed_sequencer_macros.svh"

module scss_step (
  input  logic                                clk,
  input  logic                                rst_n,
  input  scss_pkg::cfg_t                      cfg,
  input  logic                                fire,
  input  logic signed [scss_pkg::PITCH_W-1:0] pitch,
  output logic                                emit,
  output scss_pkg::result_t                   res
);

  scss_pkg::phase_t                    phase_r, phase_nxt, act;
  logic signed [scss_pkg::SPEED_W-1:0] speed_r, speed_nxt;
  logic signed [scss_pkg::PITCH_W-1:0] last_pitch_r;
  logic [scss_pkg::HOLD_W-1:0]         hold_r, hold_nxt, hold_inc;

  logic signed [scss_pkg::ANG_W-1:0]   l_ext, p_ext;
  logic                                c_acc, c_climb, c_brake;
  logic signed [scss_pkg::SPEED_W-1:0] max_ext;
  logic signed [scss_pkg::SPEED_W:0]   acc_sum;
  logic                                at_max, spd_le0, hold_end, first_hold_end;

  assign l_ext = {{(scss_pkg::ANG_W - scss_pkg::PITCH_W){last_pitch_r[scss_pkg::PITCH_W-1]}},
                  last_pitch_r};
  assign p_ext = {{(scss_pkg::ANG_W - scss_pkg::PITCH_W){cfg.flat_pitch[scss_pkg::PITCH_W-1]}},
                  cfg.flat_pitch};

  assign c_acc = l_ext >= (p_ext - scss_pkg::ONE_DEG);
  assign c_climb = l_ext <= p_ext;
  assign c_brake = l_ext >= (p_ext - scss_pkg::FIVE_DEG);

  assign max_ext = {1'b0, cfg.max_speed};
  assign at_max = speed_r >= max_ext;
  assign acc_sum = {speed_r[scss_pkg::SPEED_W-1], speed_r}
                 + {{(scss_pkg::SPEED_W + 1 - scss_pkg::STEP_W){1'b0}}, cfg.accel_step};
  assign spd_le0 = speed_r <= 16'sd0;

  assign hold_inc = hold_r + 7'd1;
  assign hold_end = hold_inc >= scss_pkg::HOLD_W'(scss_pkg::HOLD_TICKS);
  assign first_hold_end = 7'd1 >= scss_pkg::HOLD_W'(scss_pkg::HOLD_TICKS);

  // A phase whose pitch test fails hands the same tick to the next phase.
  always_comb begin
    unique case (phase_r)
      scss_pkg::PH_ACCEL: begin
        if (c_acc) act = scss_pkg::PH_ACCEL;
        else if (c_climb) act = scss_pkg::PH_CLIMB;
        else if (c_brake) act = scss_pkg::PH_BRAKE;
        else act = scss_pkg::PH_DONE;
      end
      scss_pkg::PH_CLIMB: begin
        if (c_climb) act = scss_pkg::PH_CLIMB;
        else if (c_brake) act = scss_pkg::PH_BRAKE;
        else act = scss_pkg::PH_DONE;
      end
      scss_pkg::PH_BRAKE: begin
        act = c_brake ? scss_pkg::PH_BRAKE : scss_pkg::PH_DONE;
      end
      scss_pkg::PH_PRIME: act = scss_pkg::PH_PRIME;
      scss_pkg::PH_HOLD:  act = scss_pkg::PH_HOLD;
      default:            act = scss_pkg::PH_DONE;
    endcase
  end

  // Next phase.
  always_comb begin
    unique case (act)
      scss_pkg::PH_PRIME: phase_nxt = scss_pkg::PH_ACCEL;
      scss_pkg::PH_ACCEL: phase_nxt = scss_pkg::PH_ACCEL;
      scss_pkg::PH_CLIMB: phase_nxt = scss_pkg::PH_CLIMB;
      scss_pkg::PH_BRAKE: begin
        if (!spd_le0) phase_nxt = scss_pkg::PH_BRAKE;
        else if (first_hold_end) phase_nxt = scss_pkg::PH_DONE;
        else phase_nxt = scss_pkg::PH_HOLD;
      end
      scss_pkg::PH_HOLD:  phase_nxt = hold_end ? scss_pkg::PH_DONE : scss_pkg::PH_HOLD;
      default:            phase_nxt = scss_pkg::PH_DONE;
    endcase
  end

  // Speed, hold count and the result of this tick.
  always_comb begin
    speed_nxt = speed_r;
    hold_nxt = hold_r;
    emit = 1'b0;
    res.speed_cmd = speed_r;
    res.phase = scss_pkg::OUT_PH_ACCEL;
    unique case (act)
      scss_pkg::PH_ACCEL: begin
        if (at_max) begin
          speed_nxt = max_ext;
        end else if (acc_sum > scss_pkg::SPEED_SAT) begin
          speed_nxt = scss_pkg::SPEED_SAT[scss_pkg::SPEED_W-1:0];
        end else begin
          speed_nxt = acc_sum[scss_pkg::SPEED_W-1:0];
        end
        emit = 1'b1;
        res.speed_cmd = speed_nxt;
        res.phase = scss_pkg::OUT_PH_ACCEL;
      end
      scss_pkg::PH_CLIMB: begin
        speed_nxt = max_ext;
        emit = 1'b1;
        res.speed_cmd = speed_nxt;
        res.phase = scss_pkg::OUT_PH_CLIMB;
      end
      scss_pkg::PH_BRAKE: begin
        emit = 1'b1;
        if (spd_le0) begin
          speed_nxt = '0;
          hold_nxt = 7'd1;
          res.phase = scss_pkg::OUT_PH_HOLD;
        end else begin
          speed_nxt = speed_r - {{(scss_pkg::SPEED_W - scss_pkg::STEP_W){1'b0}},
                                 cfg.decel_step};
          res.phase = scss_pkg::OUT_PH_BRAKE;
        end
        res.speed_cmd = speed_nxt;
      end
      scss_pkg::PH_HOLD: begin
        speed_nxt = '0;
        hold_nxt = hold_inc;
        emit = 1'b1;
        res.speed_cmd = '0;
        res.phase = scss_pkg::OUT_PH_HOLD;
      end
      default: ;
    endcase
    if (!fire) begin
      emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= scss_pkg::PH_PRIME;
      speed_r <= '0;
      last_pitch_r <= '0;
      hold_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      speed_r <= speed_nxt;
      hold_r <= hold_nxt;
      // The pitch is ignored once the hold has begun.
      if (phase_r != scss_pkg::PH_HOLD && phase_r != scss_pkg::PH_DONE) begin
        last_pitch_r <= pitch;
      end
    end
  end

  `SCSS_ASSERT_RST(a_done_sticks, clk, rst_n,
    (phase_r == scss_pkg::PH_DONE) |=> (phase_r == scss_pkg::PH_DONE),
    "sequencer left the done phase without a reset")
  `SCSS_ASSERT_RST(a_hold_idle_early, clk, rst_n,
    (phase_r == scss_pkg::PH_PRIME || phase_r == scss_pkg::PH_ACCEL ||
     phase_r == scss_pkg::PH_CLIMB || phase_r == scss_pkg::PH_BRAKE) |-> (hold_r == '0),
    "hold count is nonzero before the stopped hold")
  `SCSS_ASSERT_RST(a_hold_counts, clk, rst_n,
    (fire && phase_r == scss_pkg::PH_HOLD) |=>
      (hold_r == scss_pkg::HOLD_W'($past(hold_r) + 7'd1)),
    "hold count did not advance on a hold tick")
  `SCSS_ASSERT_RST(a_speed_floor, clk, rst_n,
    speed_r >= -16'sd4095,
    "speed undershot below the largest brake step")
  `SCSS_ASSERT(a_emit_needs_item, clk,
    emit |-> fire,
    "result produced without an item")

endmodule

/* rtl/core/scss_out_stage.sv */
// Output register of the sequencer: holds one speed command until the receiver takes it.
// Depends on scss_pkg and the scss_out_if interface.
module scss_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  scss_pkg::result_t res,
  output logic              can_take,
  scss_out_if.source        out_ch
);

  logic              valid_r, valid_nxt;
  scss_pkg::result_t res_r;

  // Room for a new result when empty or when the held one leaves this cycle.
  assign can_take = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.speed_cmd = res_r.speed_cmd;
  assign out_ch.phase = res_r.phase;

endmodule

/* rtl/core/slope_climb_speed_sequencer.sv */
// Slope climb speed sequencer: pitch in, forward speed command out, once per control tick.
// Depends on scss_pkg, scss_ifs, scss_cfg_regs, scss_in_stage, scss_step, scss_out_stage.
//
// Usage:
//   in_ch carries one pitch sample (1/16 degree) per tick; out_ch carries a speed command
//   (1/4096 m/s) and its phase code. cfg_we/cfg_idx/cfg_wdata write the flat-ground pitch,
//   maximum speed and the two step sizes; write them only while the block is idle.
//   After reset the first transfer only primes the previous pitch and gives no result.
//   Then each transfer gives one result in accelerate, climb, brake and stopped hold,
//   and none once the sequence is done; only a reset starts it again.
//   A sample is registered in the input register at its transfer and processed once the output
//   register has room; processing loads its result into the output register, which offers it
//   on out_ch.
//   Throughput: one transfer per cycle while the receiver does not stall, as each item reads
//   and writes the phase and speed registers in the cycle that processes it.
//   When the receiver stalls, the output register holds its result and the input register
//   takes one more sample; in_ch.ready drops only while both are full.
//   Reset (synchronous, rst_n low) empties both registers and restores register defaults.
module slope_climb_speed_sequencer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  scss_in_if.sink                              in_ch,
  scss_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [scss_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [scss_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  scss_pkg::cfg_t                      cfg;
  scss_pkg::result_t                   res;
  logic                                item_valid;
  logic signed [scss_pkg::PITCH_W-1:0] item_pitch;
  logic                                can_take;
  logic                                fire;
  logic                                emit;

  // An item is processed when the output register has room for whatever it produces.
  assign fire = item_valid && can_take;

  scss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  scss_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (fire),
    .item_valid (item_valid),
    .item_pitch (item_pitch)
  );

  scss_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .pitch (item_pitch),
    .emit  (emit),
    .res   (res)
  );

  scss_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (emit),
    .res      (res),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

endmodule

/* sim/testbench.sv */
// Self-checking bench for slope_climb_speed_sequencer: pitch samples in, speed commands out.
// Uses scss_pkg, the scss_in_if/scss_out_if interfaces and the sequencer RTL only.
module testbench;

  localparam int PITCH_MIN = -2880;
  localparam int PITCH_MAX = 2880;
  localparam int LONG_HOLD_OFF = 300;
  localparam int HOLD_OFF_AT = 400;
  localparam int DRAIN_CYCLES = 4;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [scss_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [scss_pkg::CFG_DATA_W-1:0] cfg_wdata;

  scss_in_if in_ch ();
  scss_out_if out_ch ();

  slope_climb_speed_sequencer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Local copy of the sequencer state and its register settings.
  logic signed [scss_pkg::PITCH_W-1:0] plane_cfg = '0;
  logic [scss_pkg::MAXSPD_W-1:0] max_cfg = scss_pkg::MAXSPD_W'(8192);
  logic [scss_pkg::STEP_W-1:0] accel_cfg = scss_pkg::STEP_W'(64);
  logic [scss_pkg::STEP_W-1:0] decel_cfg = scss_pkg::STEP_W'(64);
  scss_pkg::phase_t plan_phase = scss_pkg::PH_PRIME;
  logic signed [scss_pkg::SPEED_W-1:0] plan_speed = '0;
  logic signed [scss_pkg::PITCH_W-1:0] prev_pitch = '0;
  logic [scss_pkg::HOLD_W-1:0] hold_cnt = '0;

  logic signed [scss_pkg::PITCH_W-1:0] pitch_queue[$];
  scss_pkg::result_t due_cmds[$];
  int mismatches = 0;
  int accepted_cnt = 0;
  int tx_gap = 0;
  int rx_stall = 0;
  bit hold_off_done = 1'b0;

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int draw_gap();
    int r;
    r = int'($urandom_range(99));
    if (r < 65) return 0;
    if (r < 92) return int'($urandom_range(3, 1));
    return int'($urandom_range(40, 8));
  endfunction

  task automatic push_cmd(input int spd, input logic [scss_pkg::PHASE_W-1:0] ph);
    scss_pkg::result_t cmd;
    cmd.speed_cmd = scss_pkg::SPEED_W'(spd);
    cmd.phase = ph;
    due_cmds.push_back(cmd);
  endtask

  // Each decision looks at the pitch of the previous tick; a failed phase
  // test falls through to the next phase within the same tick.
  task automatic advance_speed_plan(input logic signed [scss_pkg::PITCH_W-1:0] pitch);
    int l;
    int plane;
    int spd;
    l = int'(prev_pitch);
    plane = int'(plane_cfg);
    spd = int'(plan_speed);
    if (plan_phase == scss_pkg::PH_DONE) return;
    if (plan_phase == scss_pkg::PH_HOLD) begin
      plan_speed = '0;
      hold_cnt = hold_cnt + scss_pkg::HOLD_W'(1);
      if (hold_cnt >= scss_pkg::HOLD_TICKS) plan_phase = scss_pkg::PH_DONE;
      push_cmd(0, scss_pkg::OUT_PH_HOLD);
      return;
    end
    prev_pitch = pitch;
    if (plan_phase == scss_pkg::PH_PRIME) begin
      plan_phase = scss_pkg::PH_ACCEL;
      return;
    end
    if (plan_phase == scss_pkg::PH_ACCEL) begin
      if (l >= plane - int'(scss_pkg::ONE_DEG)) begin
        if (spd >= int'(max_cfg)) begin
          spd = int'(max_cfg);
        end else begin
          spd = spd + int'(accel_cfg);
          if (spd > int'(scss_pkg::SPEED_SAT)) spd = int'(scss_pkg::SPEED_SAT);
        end
        plan_speed = scss_pkg::SPEED_W'(spd);
        push_cmd(spd, scss_pkg::OUT_PH_ACCEL);
        return;
      end
      plan_phase = scss_pkg::PH_CLIMB;
    end
    if (plan_phase == scss_pkg::PH_CLIMB) begin
      if (l <= plane) begin
        plan_speed = {1'b0, max_cfg};
        push_cmd(int'(max_cfg), scss_pkg::OUT_PH_CLIMB);
        return;
      end
      plan_phase = scss_pkg::PH_BRAKE;
    end
    if (plan_phase == scss_pkg::PH_BRAKE) begin
      if (l >= plane - int'(scss_pkg::FIVE_DEG)) begin
        if (spd <= 0) begin
          plan_speed = '0;
          hold_cnt = scss_pkg::HOLD_W'(1);
          plan_phase = (hold_cnt >= scss_pkg::HOLD_TICKS) ? scss_pkg::PH_DONE
                                                          : scss_pkg::PH_HOLD;
          push_cmd(0, scss_pkg::OUT_PH_HOLD);
          return;
        end
        plan_speed = scss_pkg::SPEED_W'(spd - int'(decel_cfg));
        push_cmd(int'(plan_speed), scss_pkg::OUT_PH_BRAKE);
        return;
      end
    end
    plan_phase = scss_pkg::PH_DONE;
  endtask

  // Sender: offers queued pitch samples with random gaps between transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.pitch <= '0;
      tx_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_speed_plan(in_ch.pitch);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the offered sample until it is taken.
      end else if (tx_gap != 0) begin
        in_ch.valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pitch_queue.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.pitch <= pitch_queue.pop_front();
        tx_gap <= draw_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready: random stalls plus one long hold-off that backs up the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_stall <= 0;
    end else if (!hold_off_done && accepted_cnt >= HOLD_OFF_AT) begin
      out_ch.ready <= 1'b0;
      rx_stall <= LONG_HOLD_OFF;
      hold_off_done <= 1'b1;
    end else if (rx_stall != 0) begin
      out_ch.ready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      rx_stall <= draw_gap();
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    scss_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_cmds.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: speed_cmd %0d phase %0d",
                                out_ch.speed_cmd, out_ch.phase));
      end else begin
        want = due_cmds.pop_front();
        if (out_ch.speed_cmd !== want.speed_cmd)
          flag_mismatch($sformatf("speed_cmd mismatch: expected %0d, got %0d",
                                  want.speed_cmd, out_ch.speed_cmd));
        if (out_ch.phase !== want.phase)
          flag_mismatch($sformatf("phase mismatch: expected %0d, got %0d",
                                  want.phase, out_ch.phase));
      end
    end
  end

  // Idle means every sample taken, every command seen, and then a DRAIN_CYCLES wait
  // for a sample that produces no command.
  task automatic wait_idle();
    do @(posedge clk);
    while (pitch_queue.size() != 0 || in_ch.valid || due_cmds.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input scss_pkg::cfg_idx_t idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= scss_pkg::CFG_DATA_W'(value);
    case (idx)
      scss_pkg::REG_FLAT_PITCH: plane_cfg = scss_pkg::PITCH_W'(value);
      scss_pkg::REG_MAX_SPEED: max_cfg = scss_pkg::MAXSPD_W'(value);
      scss_pkg::REG_ACCEL_STEP: accel_cfg = scss_pkg::STEP_W'(value);
      scss_pkg::REG_DECEL_STEP: decel_cfg = scss_pkg::STEP_W'(value);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input int plane, input int max_spd, input int acc,
                               input int dec);
    wait_idle();
    write_reg(scss_pkg::REG_FLAT_PITCH, plane);
    write_reg(scss_pkg::REG_MAX_SPEED, max_spd);
    write_reg(scss_pkg::REG_ACCEL_STEP, acc);
    write_reg(scss_pkg::REG_DECEL_STEP, dec);
  endtask

  // Random samples in [lo, hi] clipped to the legal pitch range, then a closing
  // sample that keeps the current phase valid across the next register change.
  task automatic queue_run(input int count, input int lo, input int hi, input int closing);
    int a;
    int b;
    a = (lo < PITCH_MIN) ? PITCH_MIN : lo;
    b = (hi > PITCH_MAX) ? PITCH_MAX : hi;
    for (int i = 0; i < count - 1; i++) begin
      pitch_queue.push_back(scss_pkg::PITCH_W'(pick(a, b)));
    end
    pitch_queue.push_back(scss_pkg::PITCH_W'(closing));
  endtask

  function automatic int pick_edge(input int hi);
    int r;
    r = int'($urandom_range(5));
    if (r == 0) return 0;
    if (r == 1) return hi;
    return pick(0, hi);
  endfunction

  initial begin
    int plane;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults: the first sample primes, the rest accelerate, with
    // pitches on and just above the one-degree limit.
    pitch_queue.push_back(-13'sd16);
    pitch_queue.push_back(-13'sd16);
    pitch_queue.push_back(13'sd0);
    pitch_queue.push_back(13'sd2880);
    pitch_queue.push_back(-13'sd15);
    pitch_queue.push_back(13'sd1);
    pitch_queue.push_back(13'sd100);
    pitch_queue.push_back(-13'sd16);
    pitch_queue.push_back(13'sd2879);
    pitch_queue.push_back(13'sd2000);
    pitch_queue.push_back(-13'sd1);
    pitch_queue.push_back(13'sd2880);

    // Lowest plane accepts any pitch; full steps drive the sum into saturation.
    apply_setting(PITCH_MIN, 32767, 4095, 4095);
    queue_run(120, PITCH_MIN, PITCH_MAX, PITCH_MAX);
    // Zero maximum clamps the speed down; zero steps then leave it parked.
    apply_setting(PITCH_MAX, 0, 0, 0);
    queue_run(20, PITCH_MAX - 16, PITCH_MAX, PITCH_MAX);
    plane = pick(PITCH_MIN, PITCH_MAX);
    apply_setting(plane, 32767, 0, pick(0, 4095));
    queue_run(40, plane - 16, PITCH_MAX, PITCH_MAX);
    for (int s = 0; s < 6; s++) begin
      plane = pick(PITCH_MIN, PITCH_MAX);
      apply_setting(plane, pick_edge(32767), pick_edge(4095), pick(0, 4095));
      queue_run(120, plane - 16, PITCH_MAX, PITCH_MAX);
    end

    // A sample below plane minus one degree moves the sequence into climb.
    for (int s = 0; s < 3; s++) begin
      plane = pick(-2800, 2700);
      apply_setting(plane, (s == 2) ? 32767 : pick(0, 32767), pick(0, 4095),
                    pick(0, 4095));
      if (s == 0) pitch_queue.push_back(scss_pkg::PITCH_W'(pick(PITCH_MIN, plane - 17)));
      queue_run(100, PITCH_MIN, plane, PITCH_MIN);
    end

    // A sample above the plane starts braking; a zero step holds the speed first.
    plane = pick(-2800, 2700);
    apply_setting(plane, 32767, pick(0, 4095), 0);
    pitch_queue.push_back(scss_pkg::PITCH_W'(pick(plane + 1, PITCH_MAX)));
    queue_run(40, plane - 80, PITCH_MAX, PITCH_MAX);
    plane = pick(PITCH_MIN, PITCH_MAX);
    apply_setting(plane, 32767, pick(0, 4095), pick(1, 64));
    queue_run(200, plane - 80, PITCH_MAX, PITCH_MAX);
    // Full decel step overshoots below zero, then the stopped hold runs out and
    // later samples are ignored.
    plane = pick(PITCH_MIN, PITCH_MAX);
    apply_setting(plane, pick(0, 32767), pick(0, 4095), 4095);
    queue_run(200, plane - 80, PITCH_MAX, PITCH_MAX);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && due_cmds.size() == 0) begin
      $display("slope_climb_speed_sequencer regression: pass");
    end else begin
      $display("slope_climb_speed_sequencer regression: fail");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("slope_climb_speed_sequencer regression: fail");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/scss_pkg.sv
rtl/core/scss_ifs.sv
rtl/core/scss_cfg_regs.sv
rtl/core/scss_in_stage.sv
rtl/core/scss_step.sv
rtl/core/scss_out_stage.sv
rtl/core/slope_climb_speed_sequencer.sv
sim/testbench.sv
